>>> src/rtp_header_parser_defines.svh
// ---------------------------------------------------------------------------
// rtp header parser assertion macros
// concurrent check wrappers shared by rtphp_track and rtp_header_parser, empty for synthesis
// ---------------------------------------------------------------------------
`ifndef RTP_HEADER_PARSER_DEFINES_SVH
`define RTP_HEADER_PARSER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle property, masked while in reset
`define RTPHP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent this cycle, consequent next cycle, masked while in reset
`define RTPHP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define RTPHP_ASSERT(lbl, clk, rst, prop, msg)
`define RTPHP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

>>> src/rtphp_pkg.sv
// ---------------------------------------------------------------------------
// rtphp_pkg
// shared constants, types and helpers of the rtp header parser
// ---------------------------------------------------------------------------
package rtphp_pkg;

  // longest packet kept, bytes beyond it are dropped and flagged
  localparam int MAX_LEN = 2048;
  localparam int IDX_W   = $clog2(MAX_LEN + 1);
  // header end: csrc end plus extension words, 19 bits covers the worst case
  localparam int HEND_W  = 19;
  localparam int OFS_W   = 12;

  localparam int HDR_LEN     = 12;
  localparam int WRAP_LEN    = 4;
  localparam int EXT_HDR_LEN = 4;

  localparam logic [6:0] WRAP_MARK   = 7'h56;
  localparam logic [1:0] RTP_VERSION = 2'd2;

  localparam logic [3:0] ST_OK           = 4'd0;
  localparam logic [3:0] ST_SHORT        = 4'd1;
  localparam logic [3:0] ST_BAD_VERSION  = 4'd2;
  localparam logic [3:0] ST_CSRC_OVERRUN = 4'd3;
  localparam logic [3:0] ST_EXT_CUT      = 4'd4;
  localparam logic [3:0] ST_EXT_OVERRUN  = 4'd5;
  localparam logic [3:0] ST_PAD_EMPTY    = 4'd6;
  localparam logic [3:0] ST_BAD_PAD      = 4'd7;
  localparam logic [3:0] ST_TOO_LONG     = 4'd8;

  // packet state after the current word has been taken in
  typedef struct packed {
    logic [IDX_W-1:0]  byte_index;
    logic              wrap_seen;
    logic              overflow_seen;
    logic [7:0]        first_header_byte;
    logic [7:0]        second_header_byte;
    logic [15:0]       seq;
    logic [31:0]       ts;
    logic [31:0]       src;
    logic [HEND_W-1:0] header_end;
  } hdr_state_t;

  // one result descriptor
  typedef struct packed {
    logic [3:0]       status;
    logic             wrapped;
    logic             padding_flag;
    logic             extension_flag;
    logic [3:0]       contrib_count;
    logic             marker;
    logic [6:0]       pt_code;
    logic [15:0]      sequence_res;
    logic [31:0]      timestamp;
    logic [31:0]      ssrc;
    logic [OFS_W-1:0] payload_offset;
    logic [OFS_W-1:0] payload_length;
  } desc_t;

  // end of the csrc list, counted from the rtp header start
  function automatic logic [HEND_W-1:0] csrc_end(input logic [7:0] first_byte);
    csrc_end = HEND_W'(HDR_LEN) + HEND_W'({first_byte[3:0], 2'b00});
  endfunction

  // packet state at reset and after every final word
  function automatic hdr_state_t hdr_state_init();
    hdr_state_init            = '0;
    hdr_state_init.header_end = HEND_W'(HDR_LEN);
  endfunction

endpackage

>>> src/rtphp_track.sv
// ---------------------------------------------------------------------------
// rtphp_track
// per-packet byte counter and header field capture
// ---------------------------------------------------------------------------
`include "rtp_header_parser_defines.svh"

module rtphp_track (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          data_byte,
  input  logic                last,
  output rtphp_pkg::hdr_state_t cur
);

  localparam int IDX_W_L = rtphp_pkg::IDX_W;

  rtphp_pkg::hdr_state_t state;
  rtphp_pkg::hdr_state_t state_next;
  logic [7:0]            ext_len_high;
  logic [7:0]            ext_len_high_next;
  logic [IDX_W_L-1:0]    base;
  logic [IDX_W_L-1:0]    rel;
  logic [rtphp_pkg::HEND_W-1:0] ce;

  always_comb begin
    state_next        = state;
    ext_len_high_next = ext_len_high;
    ce                = rtphp_pkg::csrc_end(state.first_header_byte);
    base              = '0;
    rel               = '0;
    if (state.byte_index == IDX_W_L'(rtphp_pkg::MAX_LEN)) begin
      state_next.overflow_seen = 1'b1;
    end else begin
      state_next.byte_index = state.byte_index + IDX_W_L'(1);
      if (state.byte_index == IDX_W_L'(1) && data_byte[6:0] == rtphp_pkg::WRAP_MARK) begin
        state_next.wrap_seen = 1'b1;
      end
      base = state_next.wrap_seen ? IDX_W_L'(rtphp_pkg::WRAP_LEN) : '0;
      if (state.byte_index >= base) begin
        rel = state.byte_index - base;
        if (rel == '0) begin
          state_next.first_header_byte = data_byte;
          state_next.header_end        = rtphp_pkg::csrc_end(data_byte);
        end else if (rel == IDX_W_L'(1)) begin
          state_next.second_header_byte = data_byte;
        end else if (rel <= IDX_W_L'(3)) begin
          state_next.seq = {state.seq[7:0], data_byte};
        end else if (rel <= IDX_W_L'(7)) begin
          state_next.ts = {state.ts[23:0], data_byte};
        end else if (rel <= IDX_W_L'(11)) begin
          state_next.src = {state.src[23:0], data_byte};
        end
        // extension length word sits two bytes into the extension header
        if (state.first_header_byte[4] && rel >= IDX_W_L'(rtphp_pkg::HDR_LEN)) begin
          if (rtphp_pkg::HEND_W'(rel) == ce + rtphp_pkg::HEND_W'(2)) begin
            ext_len_high_next = data_byte;
          end else if (rtphp_pkg::HEND_W'(rel) == ce + rtphp_pkg::HEND_W'(3)) begin
            state_next.header_end = ce + rtphp_pkg::HEND_W'(rtphp_pkg::EXT_HDR_LEN)
                                  + rtphp_pkg::HEND_W'({ext_len_high, data_byte, 2'b00});
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      state        <= rtphp_pkg::hdr_state_init();
      ext_len_high <= '0;
    end else if (step) begin
      state        <= state_next;
      ext_len_high <= ext_len_high_next;
    end
  end

  assign cur = state_next;

  `RTPHP_ASSERT(a_idx_bound, clk, rst,
    state.byte_index <= IDX_W_L'(rtphp_pkg::MAX_LEN), "byte counter past limit")
  `RTPHP_ASSERT(a_ovf_at_limit, clk, rst,
    !state.overflow_seen || state.byte_index == IDX_W_L'(rtphp_pkg::MAX_LEN),
    "overflow flagged below limit")
  `RTPHP_ASSERT_NEXT(a_end_clears, clk, rst, step && last,
    state.byte_index == '0 && !state.wrap_seen && !state.overflow_seen,
    "packet state not cleared after final word")

endmodule

>>> src/rtphp_check.sv
// ---------------------------------------------------------------------------
// rtphp_check
// end-of-packet validity checks and descriptor assembly
// ---------------------------------------------------------------------------
module rtphp_check (
  input  rtphp_pkg::hdr_state_t st,
  input  logic [7:0]            pad,
  output rtphp_pkg::desc_t      desc
);

  localparam int HW = rtphp_pkg::HEND_W;

  logic [HW-1:0] base;
  logic [HW-1:0] len;
  logic [HW-1:0] l;
  logic [HW-1:0] ce;
  logic [HW-1:0] plen;
  logic [HW-1:0] pay;
  logic [3:0]    stat;
  logic [7:0]    fhb;

  always_comb begin
    fhb  = st.first_header_byte;
    base = st.wrap_seen ? HW'(rtphp_pkg::WRAP_LEN) : '0;
    len  = HW'(st.byte_index);
    l    = len - base;
    ce   = rtphp_pkg::csrc_end(fhb);
    plen = l - st.header_end;
    pay  = '0;
    stat = rtphp_pkg::ST_OK;
    if (st.overflow_seen) begin
      stat = rtphp_pkg::ST_TOO_LONG;
    end else if (len < HW'(rtphp_pkg::HDR_LEN) ||
                 (st.wrap_seen && len < HW'(rtphp_pkg::HDR_LEN + rtphp_pkg::WRAP_LEN))) begin
      stat = rtphp_pkg::ST_SHORT;
    end else if (fhb[7:6] != rtphp_pkg::RTP_VERSION) begin
      stat = rtphp_pkg::ST_BAD_VERSION;
    end else if (ce > l) begin
      stat = rtphp_pkg::ST_CSRC_OVERRUN;
    end else if (fhb[4] && ce + HW'(rtphp_pkg::EXT_HDR_LEN) > l) begin
      stat = rtphp_pkg::ST_EXT_CUT;
    end else if (fhb[4] && st.header_end > l) begin
      stat = rtphp_pkg::ST_EXT_OVERRUN;
    end else if (fhb[5] && plen == '0) begin
      stat = rtphp_pkg::ST_PAD_EMPTY;
    end else if (fhb[5] && (pad == 8'd0 || HW'(pad) > plen)) begin
      stat = rtphp_pkg::ST_BAD_PAD;
    end else begin
      pay = fhb[5] ? plen - HW'(pad) : plen;
    end

    desc        = '0;
    desc.status = stat;
    if (stat == rtphp_pkg::ST_OK) begin
      desc.wrapped        = st.wrap_seen;
      desc.padding_flag   = fhb[5];
      desc.extension_flag = fhb[4];
      desc.contrib_count  = fhb[3:0];
      desc.marker         = st.second_header_byte[7];
      desc.pt_code        = st.second_header_byte[6:0];
      desc.sequence_res   = st.seq;
      desc.timestamp      = st.ts;
      desc.ssrc           = st.src;
      desc.payload_offset = rtphp_pkg::OFS_W'(base + st.header_end);
      desc.payload_length = rtphp_pkg::OFS_W'(pay);
    end
  end

endmodule

>>> src/rtp_header_parser.sv
// ---------------------------------------------------------------------------
// rtp_header_parser
// byte-serial rtp fixed-header parser with one descriptor per packet
// ---------------------------------------------------------------------------
// Packet bytes come in one word per cycle on the input channel, with last set
// on the final byte, and the block sustains one word every cycle without a
// stall. Each word is held in an input register, then the header tracker and
// the end of packet checks run on it and, for a final byte, the descriptor
// lands in the result register and out_valid rises. Words that are not final
// produce nothing. A wrapper whose second byte has low seven bits 0x56 is
// skipped and reported in wrapped. The final byte doubles as the pad count
// when the padding bit is set. Any status other than ok zeroes every other
// field. Bytes beyond MAX_LEN are dropped and the packet ends with status too
// long. The input stalls only while a final byte waits for a result register
// that is still held.
// ---------------------------------------------------------------------------
`include "rtp_header_parser_defines.svh"

module rtp_header_parser (
  input  logic        clk,
  input  logic        rst,
  // byte input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last,
  // descriptor output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  status,
  output logic        wrapped,
  output logic        padding_flag,
  output logic        extension_flag,
  output logic [3:0]  contrib_count,
  output logic        marker,
  output logic [6:0]  pt_code,
  output logic [15:0] sequence_res,
  output logic [31:0] timestamp,
  output logic [31:0] ssrc,
  output logic [11:0] payload_offset,
  output logic [11:0] payload_length
);

  // input register
  logic       in_q_valid;
  logic [7:0] in_q_byte;
  logic       in_q_last;

  // control
  logic slot_free;
  logic advance;

  rtphp_pkg::hdr_state_t cur;
  rtphp_pkg::desc_t      desc_next;
  rtphp_pkg::desc_t      desc;

  // result slot is free when empty or being taken this cycle
  assign slot_free = !out_valid || !out_stall;
  // non-final bytes always move on, a final byte needs the result slot
  assign advance   = in_q_valid && (!in_q_last || slot_free);
  assign in_stall  = in_q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  // payload of the input register, loaded on every accepted word
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q_byte <= data_byte;
      in_q_last <= last;
    end
  end

  // header state and field capture
  rtphp_track u_track (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (in_q_byte),
    .last      (in_q_last),
    .cur       (cur)
  );

  // end of packet checks, final byte is the pad count
  rtphp_check u_check (
    .st   (cur),
    .pad  (in_q_byte),
    .desc (desc_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_q_last) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_q_last) begin
      desc <= desc_next;
    end
  end

  assign status         = desc.status;
  assign wrapped        = desc.wrapped;
  assign padding_flag   = desc.padding_flag;
  assign extension_flag = desc.extension_flag;
  assign contrib_count  = desc.contrib_count;
  assign marker         = desc.marker;
  assign pt_code        = desc.pt_code;
  assign sequence_res   = desc.sequence_res;
  assign timestamp      = desc.timestamp;
  assign ssrc           = desc.ssrc;
  assign payload_offset = desc.payload_offset;
  assign payload_length = desc.payload_length;

  // error descriptors carry nothing but the status
  `RTPHP_ASSERT(a_err_zero, clk, rst,
    !out_valid || status == rtphp_pkg::ST_OK ||
    (payload_offset == '0 && payload_length == '0 && ssrc == '0 && timestamp == '0 &&
     sequence_res == '0 && pt_code == '0 && contrib_count == '0 && !wrapped),
    "error descriptor carries field data")
  // a good header is at least twelve bytes long
  `RTPHP_ASSERT(a_ok_offset, clk, rst,
    !out_valid || status != rtphp_pkg::ST_OK ||
    payload_offset >= 12'(rtphp_pkg::HDR_LEN),
    "ok descriptor with offset inside fixed header")
  // a final byte that moves on always loads a descriptor
  `RTPHP_ASSERT_NEXT(a_final_loads, clk, rst, advance && in_q_last, out_valid,
    "final word did not produce a descriptor")
  // the input only holds back for a final byte
  `RTPHP_ASSERT(a_stall_final, clk, rst, !in_stall || (in_q_valid && in_q_last && out_valid),
    "input stalled without a pending final word")

endmodule
